// ===== src/wbps_pkg.sv =====
// Shared types, register indexes and pattern helpers for the wildcard byte scanner.
package wbps_pkg;

	localparam int DEF_MAX_PATTERN_BYTES = 16;
	localparam int DEF_OFFSET_BITS       = 32;

	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 2;
	localparam int LEN_REG_W   = 5;
	localparam int OFFSET_W    = 32;

	localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN  = 2'd2;

	localparam logic [LEN_REG_W-1:0] LEN_RESET = 5'd1;

	// one accepted image beat handed to the scan core
	typedef struct packed {
		logic       en;
		logic [7:0] data;
		logic       last;
	} step_t;

	// result produced by the scan core for the beat being stepped
	typedef struct packed {
		logic                valid;
		logic                found;
		logic [OFFSET_W-1:0] offset;
	} result_t;

	// pattern byte idx; bytes past the two register words are wildcards
	function automatic logic [7:0] pat_byte(input logic [63:0] lo, input logic [63:0] hi,
		input int idx);
		logic [7:0] b;
		b = 8'h00;
		if (idx >= 0 && idx < 8) begin
			b = lo[8*idx +: 8];
		end else if (idx >= 8 && idx < 16) begin
			b = hi[8*(idx-8) +: 8];
		end
		return b;
	endfunction

endpackage

// ===== src/wbps_match.sv =====
// Parallel window compare against the wildcard pattern.
module wbps_match import wbps_pkg::*; #(
	parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
	parameter int LEN_W             = $clog2(MAX_PATTERN_BYTES + 1)
) (
	input  logic [7:0]       win [MAX_PATTERN_BYTES],
	input  logic [63:0]      pattern_lo,
	input  logic [63:0]      pattern_hi,
	input  logic [LEN_W-1:0] len,
	output logic             hit
);

	// window slot j (0 = newest) lines up with pattern byte len-1-j
	always_comb begin
		logic [7:0] p;
		int         pidx;
		hit = 1'b1;
		for (int j = 0; j < MAX_PATTERN_BYTES; j++) begin
			pidx = int'(len) - 1 - j;
			p    = pat_byte(pattern_lo, pattern_hi, pidx);
			if (pidx == 0) begin
				// first pattern byte: exact, even when zero
				if (win[j] != p) hit = 1'b0;
			end else if (pidx > 0) begin
				if (p != 8'h00 && win[j] != p) hit = 1'b0;
			end
		end
	end

endmodule

// ===== src/wbps_core.sv =====
// Scan state: byte window, saturating byte count, matched flag and result build.
module wbps_core import wbps_pkg::*; #(
	parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
	parameter int OFFSET_BITS       = DEF_OFFSET_BITS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  step_t                step,
	input  logic [63:0]          pattern_lo,
	input  logic [63:0]          pattern_hi,
	input  logic [LEN_REG_W-1:0] pattern_len,
	output result_t              res
);

	localparam int LEN_W = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int EXT_W = (OFFSET_BITS > OFFSET_W) ? OFFSET_BITS : OFFSET_W;

	logic [7:0]             win_q  [MAX_PATTERN_BYTES];
	logic [7:0]             win_nx [MAX_PATTERN_BYTES];
	logic [OFFSET_BITS-1:0] cnt_q;
	logic [OFFSET_BITS-1:0] cnt_nx;
	logic [OFFSET_BITS-1:0] diff;
	logic [EXT_W-1:0]       diff_ext;
	logic                   matched_q;
	logic [LEN_W-1:0]       len_act;
	logic                   hit;
	logic                   match_now;

	// zero length acts as one, oversize saturates
	always_comb begin
		if (pattern_len == '0) begin
			len_act = LEN_W'(1);
		end else if (int'(pattern_len) > MAX_PATTERN_BYTES) begin
			len_act = LEN_W'(MAX_PATTERN_BYTES);
		end else begin
			len_act = LEN_W'(pattern_len);
		end
	end

	always_comb begin
		win_nx[0] = step.data;
		for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
			win_nx[k] = win_q[k-1];
		end
	end

	assign cnt_nx = (cnt_q == '1) ? cnt_q : cnt_q + 1'b1;

	wbps_match #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
		.LEN_W            (LEN_W)
	) u_match (
		.win       (win_nx),
		.pattern_lo(pattern_lo),
		.pattern_hi(pattern_hi),
		.len       (len_act),
		.hit       (hit)
	);

	assign match_now = hit && (cnt_nx >= OFFSET_BITS'(len_act));
	assign diff      = cnt_nx - OFFSET_BITS'(len_act);
	assign diff_ext  = EXT_W'(diff);

	always_comb begin
		res = '0;
		if (step.en && !matched_q) begin
			if (match_now) begin
				res.valid  = 1'b1;
				res.found  = 1'b1;
				res.offset = diff_ext[OFFSET_W-1:0];
			end else if (step.last) begin
				res.valid = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_PATTERN_BYTES; k++) win_q[k] <= 8'h00;
			cnt_q     <= '0;
			matched_q <= 1'b0;
		end else if (step.en) begin
			if (step.last) begin
				// end of image: rearm
				for (int k = 0; k < MAX_PATTERN_BYTES; k++) win_q[k] <= 8'h00;
				cnt_q     <= '0;
				matched_q <= 1'b0;
			end else if (!matched_q) begin
				win_q     <= win_nx;
				cnt_q     <= cnt_nx;
				matched_q <= match_now;
			end
		end
	end

endmodule

// ===== src/wildcard_byte_pattern_search.sv =====
// Top level of the wildcard byte signature scanner.
//
//  channel   signals                                  direction
//  image     in_valid/in_ready, image_byte, last_byte  in
//  result    out_valid/out_ready, found, match_offset  out
//  config    cfg_we, cfg_index, cfg_data               in (write only)
//
// One image byte per cycle while in_ready is high: a beat lands in the _s1
// input register, the window shift and parallel compare run when it moves on,
// and any result lands in the output register.
// in_ready drops only when the input register is full and the output
// register holds a result nobody has taken. Reset clears the window, count,
// matched flag and config (pattern length resets to one).
module wildcard_byte_pattern_search import wbps_pkg::*; #(
	parameter int MAX_PATTERN_BYTES = DEF_MAX_PATTERN_BYTES,
	parameter int OFFSET_BITS       = DEF_OFFSET_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             image_byte,
	input  logic                   last_byte,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   found,
	output logic [OFFSET_W-1:0]    match_offset,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// config registers
	logic [63:0]          pattern_lo_q;
	logic [63:0]          pattern_hi_q;
	logic [LEN_REG_W-1:0] pattern_len_q;

	// input stage
	logic       valid_s1;
	logic [7:0] image_byte_s1;
	logic       last_byte_s1;
	logic       adv;

	// output register
	logic                out_valid_q;
	logic                found_q;
	logic [OFFSET_W-1:0] match_offset_q;

	step_t   step;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_lo_q  <= '0;
			pattern_hi_q  <= '0;
			pattern_len_q <= LEN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_PATTERN_LOW:  pattern_lo_q  <= cfg_data;
				CFG_PATTERN_HIGH: pattern_hi_q  <= cfg_data;
				CFG_PATTERN_LEN:  pattern_len_q <= cfg_data[LEN_REG_W-1:0];
				default: ;  // unmapped index, write dropped
			endcase
		end
	end

	// the staged beat moves on whenever the output register can take a result
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			image_byte_s1 <= image_byte;
			last_byte_s1  <= last_byte;
		end
	end

	assign step.en   = adv;
	assign step.data = image_byte_s1;
	assign step.last = last_byte_s1;

	wbps_core #(
		.MAX_PATTERN_BYTES(MAX_PATTERN_BYTES),
		.OFFSET_BITS      (OFFSET_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.pattern_lo (pattern_lo_q),
		.pattern_hi (pattern_hi_q),
		.pattern_len(pattern_len_q),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			found_q        <= res.found;
			match_offset_q <= res.offset;
		end
	end

	assign out_valid    = out_valid_q;
	assign found        = found_q;
	assign match_offset = match_offset_q;

	// a not-found beat always reports offset zero
	a_notfound_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> match_offset == '0)
		else $error("not-found result with nonzero offset");

	// a beat held in the input stage keeps its byte while the result side stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(image_byte_s1) && $stable(last_byte_s1))
		else $error("staged beat lost during stall");

	// an empty input stage never refuses a beat
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input refused with empty stage");

endmodule
